[rtl/core/tlo_pkg.sv]
// Shared types, constants and saturation helpers for the trainer load offset controller.
package tlo_pkg;

  // Field widths fixed by the register map and result format
  localparam int MODE_W     = 2;
  localparam int PCT_W      = 10;
  localparam int WATTS_W    = 11;
  localparam int SF_W       = 17;
  localparam int GAIN_W     = 16;
  localparam int ERR_W      = 21;
  localparam int TERM_W     = 40;
  localparam int ADJ_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Shared multiplier, sized for the widest power field
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 27;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Internal working widths
  localparam int ERRX_W      = 26;  // raw error before saturation
  localparam int TERMX_W     = 48;  // term before saturation
  localparam int ACC_W       = 56;  // gain_i * integral
  localparam int SUM_W       = 42;  // p + i + d
  localparam int ADJX_W      = 34;  // sum / 256 before saturation
  localparam int INTEG_SPLIT = 20;  // integral split for two partial products
  localparam int FRAC_W      = 8;   // Q.8 watts
  localparam int Q16_W       = 16;

  localparam logic [SF_W-1:0] ONE_Q16      = 17'd65536;
  localparam logic [25:0]     RECIP_100    = 26'd42949672;  // floor(2^32 / 100)
  localparam int              RECIP_SHIFT  = 32;
  localparam logic signed [7:0] HUNDRED    = 8'sd100;
  localparam logic signed [8:0] RND_DIV256 = 9'sd255;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_MODE = 3'd0,
    CFG_MANUAL_PCT  = 3'd1,
    CFG_MANUAL_W    = 3'd2,
    CFG_SMOOTHING   = 3'd3,
    CFG_GAIN_P      = 3'd4,
    CFG_GAIN_I      = 3'd5,
    CFG_GAIN_D      = 3'd6,
    CFG_UNUSED      = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NOP       = 5'd0,
    OP_CAPTURE   = 5'd1,
    OP_CLEAR     = 5'd2,
    OP_ZERO_ADJ  = 5'd3,
    OP_MUL_EWMA  = 5'd4,
    OP_SMOOTH    = 5'd5,
    OP_ERROR     = 5'd6,
    OP_INTEG     = 5'd7,
    OP_MUL_D     = 5'd8,
    OP_MUL_ILO   = 5'd9,
    OP_MUL_IHI   = 5'd10,
    OP_IACC      = 5'd11,
    OP_SUM       = 5'd12,
    OP_ADJ       = 5'd13,
    OP_MUL_PCT   = 5'd14,
    OP_NUM       = 5'd15,
    OP_MUL_RECIP = 5'd16,
    OP_QUOT      = 5'd17,
    OP_FIX       = 5'd18,
    OP_SIGN      = 5'd19,
    OP_OUT       = 5'd20
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic  zero_in;
    mode_t mode;
  } status_t;

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ERRX_W-1:0] x);
    if (&x[ERRX_W-1:ERR_W-1] || ~|x[ERRX_W-1:ERR_W-1])
      return x[ERR_W-1:0];
    else
      return x[ERRX_W-1] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
  endfunction

  function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [TERMX_W-1:0] x);
    if (&x[TERMX_W-1:TERM_W-1] || ~|x[TERMX_W-1:TERM_W-1])
      return x[TERM_W-1:0];
    else
      return x[TERMX_W-1] ? {1'b1, {(TERM_W-1){1'b0}}} : {1'b0, {(TERM_W-1){1'b1}}};
  endfunction

  function automatic logic signed [ADJ_W-1:0] sat_adj(input logic signed [ADJX_W-1:0] x);
    if (&x[ADJX_W-1:ADJ_W-1] || ~|x[ADJX_W-1:ADJ_W-1])
      return x[ADJ_W-1:0];
    else
      return x[ADJX_W-1] ? {1'b1, {(ADJ_W-1){1'b0}}} : {1'b0, {(ADJ_W-1){1'b1}}};
  endfunction

endpackage

[rtl/core/tlo_if.sv]
// Request and result channel interfaces for the trainer load offset controller.
interface tlo_sample_if #(
  parameter int POWER_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [POWER_BITS-1:0] target_load;
  logic [POWER_BITS-1:0] measured_power;

  modport source (output valid, output target_load, output measured_power, input ready);
  modport sink   (input valid, input target_load, input measured_power, output ready);
endinterface

interface tlo_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [tlo_pkg::ADJ_W-1:0]  load_adjustment;
  logic signed [tlo_pkg::ERR_W-1:0]  control_error;
  logic signed [tlo_pkg::TERM_W-1:0] term_p;
  logic signed [tlo_pkg::TERM_W-1:0] term_i;
  logic signed [tlo_pkg::TERM_W-1:0] term_d;

  modport source (output valid, output load_adjustment, output control_error,
                  output term_p, output term_i, output term_d, input ready);
  modport sink   (input valid, input load_adjustment, input control_error,
                  input term_p, input term_i, input term_d, output ready);
endinterface

[rtl/core/tlo_ctrl.sv]
// Trainer load offset sequencer: issues one datapath step per cycle while not stalled.
module tlo_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  tlo_pkg::status_t status,
  output tlo_pkg::cmd_t    cmd
);

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_CLEAR  = 20'h00002,
    ST_ZADJ   = 20'h00004,
    ST_EWMA   = 20'h00008,
    ST_SMOOTH = 20'h00010,
    ST_ERROR  = 20'h00020,
    ST_INTEG  = 20'h00040,
    ST_MULD   = 20'h00080,
    ST_MULILO = 20'h00100,
    ST_MULIHI = 20'h00200,
    ST_IACC   = 20'h00400,
    ST_SUM    = 20'h00800,
    ST_ADJ    = 20'h01000,
    ST_PCT    = 20'h02000,
    ST_NUM    = 20'h04000,
    ST_RECIP  = 20'h08000,
    ST_QUOT   = 20'h10000,
    ST_FIX    = 20'h20000,
    ST_SIGN   = 20'h40000,
    ST_OUT    = 20'h80000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.op     = tlo_pkg::OP_NOP;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = tlo_pkg::OP_CAPTURE;
          if (status.zero_in) begin
            state_next = ST_CLEAR;
          end else begin
            case (status.mode)
              tlo_pkg::MODE_AUTO:   state_next = ST_EWMA;
              tlo_pkg::MODE_MANUAL: state_next = ST_PCT;
              default:              state_next = ST_ZADJ;
            endcase
          end
        end
      end
      ST_CLEAR:  begin cmd.op = tlo_pkg::OP_CLEAR;     state_next = ST_OUT;    end
      ST_ZADJ:   begin cmd.op = tlo_pkg::OP_ZERO_ADJ;  state_next = ST_OUT;    end
      ST_EWMA:   begin cmd.op = tlo_pkg::OP_MUL_EWMA;  state_next = ST_SMOOTH; end
      ST_SMOOTH: begin cmd.op = tlo_pkg::OP_SMOOTH;    state_next = ST_ERROR;  end
      ST_ERROR:  begin cmd.op = tlo_pkg::OP_ERROR;     state_next = ST_INTEG;  end
      ST_INTEG:  begin cmd.op = tlo_pkg::OP_INTEG;     state_next = ST_MULD;   end
      ST_MULD:   begin cmd.op = tlo_pkg::OP_MUL_D;     state_next = ST_MULILO; end
      ST_MULILO: begin cmd.op = tlo_pkg::OP_MUL_ILO;   state_next = ST_MULIHI; end
      ST_MULIHI: begin cmd.op = tlo_pkg::OP_MUL_IHI;   state_next = ST_IACC;   end
      ST_IACC:   begin cmd.op = tlo_pkg::OP_IACC;      state_next = ST_SUM;    end
      ST_SUM:    begin cmd.op = tlo_pkg::OP_SUM;       state_next = ST_ADJ;    end
      ST_ADJ:    begin cmd.op = tlo_pkg::OP_ADJ;       state_next = ST_OUT;    end
      ST_PCT:    begin cmd.op = tlo_pkg::OP_MUL_PCT;   state_next = ST_NUM;    end
      ST_NUM:    begin cmd.op = tlo_pkg::OP_NUM;       state_next = ST_RECIP;  end
      ST_RECIP:  begin cmd.op = tlo_pkg::OP_MUL_RECIP; state_next = ST_QUOT;   end
      ST_QUOT:   begin cmd.op = tlo_pkg::OP_QUOT;      state_next = ST_FIX;    end
      ST_FIX:    begin cmd.op = tlo_pkg::OP_FIX;       state_next = ST_SIGN;   end
      ST_SIGN:   begin cmd.op = tlo_pkg::OP_SIGN;      state_next = ST_OUT;    end
      ST_OUT: begin
        if (out_free) begin
          cmd.op     = tlo_pkg::OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

endmodule

[rtl/core/tlo_datapath.sv]
// Datapath: config registers, EWMA, PID and manual offset math on one shared multiplier.
module tlo_datapath #(
  parameter int POWER_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tlo_pkg::cmd_t                       cmd,
  output tlo_pkg::status_t                    status,
  input  logic                                cfg_we,
  input  logic [tlo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tlo_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [POWER_BITS-1:0]               target_load,
  input  logic [POWER_BITS-1:0]               measured_power,
  output logic signed [tlo_pkg::ADJ_W-1:0]    load_adjustment,
  output logic signed [tlo_pkg::ERR_W-1:0]    control_error,
  output logic signed [tlo_pkg::TERM_W-1:0]   term_p,
  output logic signed [tlo_pkg::TERM_W-1:0]   term_i,
  output logic signed [tlo_pkg::TERM_W-1:0]   term_d
);

  localparam int SW = POWER_BITS + tlo_pkg::FRAC_W;  // smoothed power, Q.8
  localparam int NW = POWER_BITS + 12;               // manual numerator, signed
  localparam int QW = NW - 6;                        // manual quotient

  // Config registers
  tlo_pkg::mode_t                       mode_r;
  logic [tlo_pkg::PCT_W-1:0]            pct_r;
  logic signed [tlo_pkg::WATTS_W-1:0]   watts_r;
  logic [tlo_pkg::SF_W-1:0]             sf_r;
  logic signed [tlo_pkg::GAIN_W-1:0]    gain_p_r, gain_i_r, gain_d_r;

  // Controller state
  logic [POWER_BITS-1:0]                load_r, power_r;
  logic [SW-1:0]                        smooth_r;
  logic signed [tlo_pkg::ERR_W-1:0]     err_r, prev_r;
  logic signed [tlo_pkg::TERM_W-1:0]    integ_r, p_r, i_r, d_r;
  logic signed [tlo_pkg::ADJ_W-1:0]     adj_r;

  // Working registers
  logic signed [tlo_pkg::MUL_P_W-1:0]   prod_r;
  logic signed [tlo_pkg::ACC_W-1:0]     acc_r;
  logic signed [tlo_pkg::SUM_W-1:0]     sum_r;
  logic [NW-1:0]                        nabs_r;
  logic                                 nneg_r;
  logic [QW-1:0]                        q_r;

  // Combinational
  logic signed [tlo_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [tlo_pkg::MUL_B_W-1:0]   mul_b;
  logic [tlo_pkg::SF_W-1:0]             alpha;
  logic signed [SW:0]                   ewma_diff, err_diff;
  logic signed [tlo_pkg::MUL_P_W:0]     ewma_sum;
  logic signed [tlo_pkg::ERR_W-1:0]     err_sat;
  logic signed [tlo_pkg::TERM_W:0]      integ_sum;
  logic signed [tlo_pkg::ERR_W:0]       derr;
  logic signed [tlo_pkg::ACC_W-1:0]     acc_sum, acc_shift;
  logic signed [tlo_pkg::SUM_W-1:0]     sum_rnd, sum_shift;
  logic signed [NW-1:0]                 watts_less_load, num;
  logic signed [NW:0]                   rem;
  logic signed [tlo_pkg::ADJ_W-1:0]     q_ext;

  assign status.zero_in = (target_load == '0) || (measured_power == '0);
  assign status.mode    = mode_r;

  assign alpha     = (sf_r > tlo_pkg::ONE_Q16) ? tlo_pkg::ONE_Q16 : sf_r;
  assign ewma_diff = $signed({1'b0, power_r, {tlo_pkg::FRAC_W{1'b0}}}) - $signed({1'b0, smooth_r});
  assign err_diff  = $signed({1'b0, load_r, {tlo_pkg::FRAC_W{1'b0}}}) - $signed({1'b0, smooth_r});

  // s + a*(P - s) in Q.24, rounded half up back to Q.8
  assign ewma_sum = $signed((tlo_pkg::MUL_P_W+1)'({smooth_r, {tlo_pkg::Q16_W{1'b0}}}))
                  + (tlo_pkg::MUL_P_W+1)'(prod_r)
                  + $signed((tlo_pkg::MUL_P_W+1)'(tlo_pkg::ONE_Q16 >> 1));

  assign err_sat   = tlo_pkg::sat_err(tlo_pkg::ERRX_W'(err_diff));
  assign integ_sum = (tlo_pkg::TERM_W+1)'(integ_r) + (tlo_pkg::TERM_W+1)'(err_r);
  assign derr      = (tlo_pkg::ERR_W+1)'(err_r) - (tlo_pkg::ERR_W+1)'(prev_r);

  assign acc_sum   = acc_r + (tlo_pkg::ACC_W'(prod_r) <<< tlo_pkg::INTEG_SPLIT);
  assign acc_shift = acc_sum >>> tlo_pkg::FRAC_W;

  // divide by 256 truncating toward zero
  assign sum_rnd   = sum_r + (sum_r[tlo_pkg::SUM_W-1] ? tlo_pkg::SUM_W'(tlo_pkg::RND_DIV256)
                                                      : tlo_pkg::SUM_W'(8'sd0));
  assign sum_shift = sum_rnd >>> tlo_pkg::FRAC_W;

  assign watts_less_load = NW'(watts_r) - $signed(NW'(load_r));
  assign num             = NW'(prod_r) + watts_less_load * tlo_pkg::HUNDRED;
  assign rem             = $signed({1'b0, nabs_r}) - $signed({1'b0, NW'(q_r)}) * tlo_pkg::HUNDRED;
  assign q_ext           = $signed(tlo_pkg::ADJ_W'(q_r));

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      tlo_pkg::OP_MUL_EWMA: begin
        mul_a = tlo_pkg::MUL_A_W'(ewma_diff);
        mul_b = $signed(tlo_pkg::MUL_B_W'(alpha));
      end
      tlo_pkg::OP_INTEG: begin
        mul_a = tlo_pkg::MUL_A_W'(err_r);
        mul_b = tlo_pkg::MUL_B_W'(gain_p_r);
      end
      tlo_pkg::OP_MUL_D: begin
        mul_a = tlo_pkg::MUL_A_W'(derr);
        mul_b = tlo_pkg::MUL_B_W'(gain_d_r);
      end
      tlo_pkg::OP_MUL_ILO: begin
        mul_a = $signed(tlo_pkg::MUL_A_W'(integ_r[tlo_pkg::INTEG_SPLIT-1:0]));
        mul_b = tlo_pkg::MUL_B_W'(gain_i_r);
      end
      tlo_pkg::OP_MUL_IHI: begin
        mul_a = tlo_pkg::MUL_A_W'($signed(integ_r[tlo_pkg::TERM_W-1:tlo_pkg::INTEG_SPLIT]));
        mul_b = tlo_pkg::MUL_B_W'(gain_i_r);
      end
      tlo_pkg::OP_MUL_PCT: begin
        mul_a = $signed(tlo_pkg::MUL_A_W'(load_r));
        mul_b = $signed(tlo_pkg::MUL_B_W'(pct_r));
      end
      tlo_pkg::OP_MUL_RECIP: begin
        mul_a = $signed(tlo_pkg::MUL_A_W'(nabs_r));
        mul_b = $signed(tlo_pkg::MUL_B_W'(tlo_pkg::RECIP_100));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Product is consumed by the step right after the one that issued it
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r   <= tlo_pkg::MODE_NONE;
      pct_r    <= '0;
      watts_r  <= '0;
      sf_r     <= tlo_pkg::ONE_Q16;
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
    end else if (cfg_we) begin
      case (tlo_pkg::cfg_idx_t'(cfg_index))
        tlo_pkg::CFG_OFFSET_MODE: mode_r   <= tlo_pkg::mode_t'(cfg_data[tlo_pkg::MODE_W-1:0]);
        tlo_pkg::CFG_MANUAL_PCT:  pct_r    <= cfg_data[tlo_pkg::PCT_W-1:0];
        tlo_pkg::CFG_MANUAL_W:    watts_r  <= $signed(cfg_data[tlo_pkg::WATTS_W-1:0]);
        tlo_pkg::CFG_SMOOTHING:   sf_r     <= cfg_data[tlo_pkg::SF_W-1:0];
        tlo_pkg::CFG_GAIN_P:      gain_p_r <= $signed(cfg_data[tlo_pkg::GAIN_W-1:0]);
        tlo_pkg::CFG_GAIN_I:      gain_i_r <= $signed(cfg_data[tlo_pkg::GAIN_W-1:0]);
        tlo_pkg::CFG_GAIN_D:      gain_d_r <= $signed(cfg_data[tlo_pkg::GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // Controller state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_r <= '0;
      err_r    <= '0;
      prev_r   <= '0;
      integ_r  <= '0;
      adj_r    <= '0;
      p_r      <= '0;
      i_r      <= '0;
      d_r      <= '0;
    end else begin
      case (cmd.op)
        tlo_pkg::OP_CLEAR: begin
          err_r   <= '0;
          prev_r  <= '0;
          integ_r <= '0;
          adj_r   <= '0;
          p_r     <= '0;
          i_r     <= '0;
          d_r     <= '0;
        end
        tlo_pkg::OP_ZERO_ADJ: adj_r    <= '0;
        tlo_pkg::OP_SMOOTH:   smooth_r <= ewma_sum[tlo_pkg::Q16_W +: SW];
        tlo_pkg::OP_ERROR:    err_r    <= err_sat;
        tlo_pkg::OP_INTEG:    integ_r  <= tlo_pkg::sat_term(tlo_pkg::TERMX_W'(integ_sum));
        tlo_pkg::OP_MUL_D:    p_r      <= tlo_pkg::TERM_W'(prod_r >>> tlo_pkg::FRAC_W);
        tlo_pkg::OP_MUL_ILO: begin
          d_r    <= tlo_pkg::TERM_W'(prod_r >>> tlo_pkg::FRAC_W);
          prev_r <= err_r;
        end
        tlo_pkg::OP_IACC:     i_r      <= tlo_pkg::sat_term(tlo_pkg::TERMX_W'(acc_shift));
        tlo_pkg::OP_ADJ:      adj_r    <= tlo_pkg::sat_adj(tlo_pkg::ADJX_W'(sum_shift));
        tlo_pkg::OP_SIGN:     adj_r    <= nneg_r ? -q_ext : q_ext;
        default: ;
      endcase
    end
  end

  // Payload and scratch registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      tlo_pkg::OP_CAPTURE: begin
        load_r  <= target_load;
        power_r <= measured_power;
      end
      tlo_pkg::OP_MUL_IHI: acc_r <= tlo_pkg::ACC_W'(prod_r);
      tlo_pkg::OP_SUM: begin
        sum_r <= tlo_pkg::SUM_W'(p_r) + tlo_pkg::SUM_W'(i_r) + tlo_pkg::SUM_W'(d_r);
      end
      tlo_pkg::OP_NUM: begin
        nneg_r <= num[NW-1];
        nabs_r <= num[NW-1] ? NW'(-num) : NW'(num);
      end
      tlo_pkg::OP_QUOT: q_r <= prod_r[tlo_pkg::RECIP_SHIFT +: QW];
      tlo_pkg::OP_FIX: begin
        if (rem >= tlo_pkg::HUNDRED)
          q_r <= q_r + QW'(1);
      end
      tlo_pkg::OP_OUT: begin
        load_adjustment <= adj_r;
        control_error   <= err_r;
        term_p          <= p_r;
        term_i          <= i_r;
        term_d          <= d_r;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/trainer_load_offset_pid_top.sv]
// Top level of the trainer load offset controller.
// Usage:
//   sample  - request channel (valid/ready): target_load and measured_power in
//             whole watts. A request with either field zero clears the error,
//             integral, terms and adjustment (the smoothed power is kept).
//   result  - one result per request: load_adjustment (watts), control_error
//             and the P, I, D terms (Q.8 watts), all as stored after the step.
//   cfg_*   - register writes (mode, manual percent/watts, smoothing, gains),
//             taken on any cycle with cfg_we high; write only while idle.
// From request accept to result valid, auto mode runs the most steps, manual
// mode fewer, and a zero request or mode none the fewest. One request is in
// flight at a time: a new request is taken only in idle, after the last one
// has run its steps. The steps are set around the single shared 28x27
// multiplier (EWMA, P, D, two integral partial products; load*percent and
// the /100 reciprocal in manual mode).
// The result sits in an output register; a stalled receiver holds the finished
// result while the next request may be accepted and worked on; that request
// then waits in its last step until the register frees up.
// Reset (rst, synchronous) clears all controller state and the result valid,
// and loads the register reset values (smoothing factor one, all else zero).
module trainer_load_offset_pid_top #(
  parameter int POWER_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  tlo_sample_if.sink                          sample,
  tlo_result_if.source                        result,
  input  logic                                cfg_we,
  input  logic [tlo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tlo_pkg::CFG_DATA_W-1:0]      cfg_data
);

  tlo_pkg::cmd_t    cmd;
  tlo_pkg::status_t status;

  // Sequencer: one datapath step per cycle unless stalled; owns handshakes
  tlo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic, config bank and the result register
  tlo_datapath #(
    .POWER_BITS (POWER_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .target_load     (sample.target_load),
    .measured_power  (sample.measured_power),
    .load_adjustment (result.load_adjustment),
    .control_error   (result.control_error),
    .term_p          (result.term_p),
    .term_i          (result.term_i),
    .term_d          (result.term_d)
  );

endmodule

[rtl/core/tlo_checker.sv]
// Port-level assertions for the trainer load offset controller, bound to the top level.
module tlo_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [tlo_pkg::ADJ_W-1:0]   load_adjustment,
  input logic signed [tlo_pkg::ERR_W-1:0]   control_error
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(load_adjustment) && $stable(control_error))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Only one request in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // No result can appear in the cycle right after a request is taken
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early");

endmodule

bind trainer_load_offset_pid_top tlo_checker u_tlo_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (sample.valid),
  .in_ready        (sample.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .load_adjustment (result.load_adjustment),
  .control_error   (result.control_error)
);

[verif/tb_trainer_load_offset_pid_top.sv]
// Self-checking testbench for trainer_load_offset_pid_top: predicts every result and compares it.
module tb_trainer_load_offset_pid_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlo_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 8;
  localparam int POWER_W        = 12;
  // settle time after the last result, enough for the longest (auto-mode) request
  localparam int SETTLE_CYCLES  = 16;
  // cycles with no request and no result accepted before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_REQUESTS = 50;
  // a run of max-error steps that keeps growing the integral
  localparam int SOAK_REQUESTS  = 25;

  typedef struct {
    logic [POWER_W-1:0] load;
    logic [POWER_W-1:0] power;
    bit                 drain_first;  // hold this request until every result is back
  } load_request_t;

  typedef struct packed {
    logic signed [ADJ_W-1:0]  adj;
    logic signed [ERR_W-1:0]  err;
    logic signed [TERM_W-1:0] p;
    logic signed [TERM_W-1:0] i;
    logic signed [TERM_W-1:0] d;
  } offset_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tlo_sample_if #(.POWER_BITS(POWER_W)) sample_ch ();
  tlo_result_if                         result_ch ();

  trainer_load_offset_pid_top #(.POWER_BITS(POWER_W)) dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Register mirror, kept in step with every write
  mode_t  reg_mode;
  int     reg_percent;
  int     reg_watts;
  int     reg_alpha;
  int     reg_kp;
  int     reg_ki;
  int     reg_kd;

  // Controller state as the predictor sees it
  longint pid_smooth;
  longint pid_err;
  longint pid_err_prev;
  longint pid_integral;
  longint pid_adj;
  longint pid_p;
  longint pid_i;
  longint pid_d;

  load_request_t  pending_samples[$];   // requests not yet offered to the block
  offset_result_t expected_offsets[$];  // predictions waiting for their result
  int             offsets_owed;         // queued requests whose result is not checked yet
  bit             sample_taken;         // a request was accepted at the last rising edge
  int             send_idle_pct;
  int             stall_pct;
  int             fault_count;
  int             stall_cycles;

  function automatic longint clamp_bits(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One controller step on an accepted request; advances the predicted state.
  function automatic offset_result_t predict_offset(input logic [POWER_W-1:0] load_w,
                                                     input logic [POWER_W-1:0] power_w);
    offset_result_t res;
    longint ld;
    longint pw;
    longint alpha;
    longint num;
    longint e;
    ld = longint'(load_w);
    pw = longint'(power_w);
    if (ld == 0 || pw == 0) begin
      // a zero field clears everything but the smoothed power
      pid_err      = 0;
      pid_err_prev = 0;
      pid_integral = 0;
      pid_adj      = 0;
      pid_p        = 0;
      pid_i        = 0;
      pid_d        = 0;
    end else if (reg_mode == MODE_MANUAL) begin
      num     = ld * reg_percent + 100 * (reg_watts - ld);
      pid_adj = clamp_bits(num / 100, ADJ_W);
    end else if (reg_mode == MODE_AUTO) begin
      // weights above one act as one
      alpha        = (reg_alpha > 65536) ? 65536 : reg_alpha;
      num          = alpha * (pw <<< FRAC_W) + (65536 - alpha) * pid_smooth;
      pid_smooth   = (num + 32768) >>> Q16_W;
      e            = clamp_bits((ld <<< FRAC_W) - pid_smooth, ERR_W);
      pid_err      = e;
      pid_integral = clamp_bits(pid_integral + e, TERM_W);
      // arithmetic shift on a signed product floors toward minus infinity
      pid_p        = clamp_bits((reg_kp * e) >>> FRAC_W, TERM_W);
      pid_i        = clamp_bits((reg_ki * pid_integral) >>> FRAC_W, TERM_W);
      pid_d        = clamp_bits((reg_kd * (e - pid_err_prev)) >>> FRAC_W, TERM_W);
      pid_adj      = clamp_bits((pid_p + pid_i + pid_d) / 256, ADJ_W);
      pid_err_prev = e;
    end else begin
      // none and the reserved code: zero offset, stored terms still reported
      pid_adj = 0;
    end
    res.adj = pid_adj[ADJ_W-1:0];
    res.err = pid_err[ERR_W-1:0];
    res.p   = pid_p[TERM_W-1:0];
    res.i   = pid_i[TERM_W-1:0];
    res.d   = pid_d[TERM_W-1:0];
    return res;
  endfunction

  // Register write on the next falling edge; raw 17-bit data, field masking left to the block.
  task automatic write_reg(input cfg_idx_t idx, input int value);
    logic [CFG_DATA_W-1:0] data;
    data = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_OFFSET_MODE: reg_mode    = mode_t'(data[MODE_W-1:0]);
      CFG_MANUAL_PCT:  reg_percent = int'(data[PCT_W-1:0]);
      CFG_MANUAL_W:    reg_watts   = int'($signed(data[WATTS_W-1:0]));
      CFG_SMOOTHING:   reg_alpha   = int'(data[SF_W-1:0]);
      CFG_GAIN_P:      reg_kp      = int'($signed(data[GAIN_W-1:0]));
      CFG_GAIN_I:      reg_ki      = int'($signed(data[GAIN_W-1:0]));
      CFG_GAIN_D:      reg_kd      = int'($signed(data[GAIN_W-1:0]));
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_sample(input int load_w, input int power_w, input bit drain);
    load_request_t req;
    req.load        = load_w[POWER_W-1:0];
    req.power       = power_w[POWER_W-1:0];
    req.drain_first = drain;
    pending_samples.push_back(req);
    offsets_owed++;
  endtask

  // Returns on a falling edge once every queued request has its result checked.
  task automatic wait_idle();
    while (offsets_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Request driver and result-ready generator; both change on the falling edge.
  always @(negedge clk) begin
    load_request_t nxt;
    if (rst) begin
      sample_ch.valid <= 1'b0;
      result_ch.ready <= 1'b0;
    end else begin
      // a raised valid holds its request until the block takes it
      if (!sample_ch.valid || sample_taken) begin
        if (pending_samples.size() != 0 &&
            (!pending_samples[0].drain_first || expected_offsets.size() == 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_samples.pop_front();
          sample_ch.valid          <= 1'b1;
          sample_ch.target_load    <= nxt.load;
          sample_ch.measured_power <= nxt.power;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: checks results against the oldest prediction, predicts accepted
  // requests, and runs the watchdog. A result and a request taken on the same
  // edge never belong together, so the check goes first.
  always @(posedge clk) begin
    offset_result_t got;
    offset_result_t want;
    offset_result_t pred;
    bit             moved;
    sample_taken = 1'b0;
    moved        = 1'b0;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        moved   = 1'b1;
        got.adj = result_ch.load_adjustment;
        got.err = result_ch.control_error;
        got.p   = result_ch.term_p;
        got.i   = result_ch.term_i;
        got.d   = result_ch.term_d;
        if (expected_offsets.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("unexpected result: adj=%0d err=%0d p=%0d i=%0d d=%0d",
                     got.adj, got.err, got.p, got.i, got.d);
        end else begin
          want = expected_offsets.pop_front();
          offsets_owed--;
          if (got.adj !== want.adj || got.err !== want.err || got.p !== want.p ||
              got.i !== want.i || got.d !== want.d) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
              $display("offset mismatch: exp adj=%0d err=%0d p=%0d i=%0d d=%0d",
                       want.adj, want.err, want.p, want.i, want.d);
              $display("                 got adj=%0d err=%0d p=%0d i=%0d d=%0d",
                       got.adj, got.err, got.p, got.i, got.d);
            end
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        moved        = 1'b1;
        sample_taken = 1'b1;
        pred = predict_offset(sample_ch.target_load, sample_ch.measured_power);
        expected_offsets.push_back(pred);
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("trainer_load_offset_pid_top regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    int ph;
    int n;
    int kind;
    int ld;
    int pw;
    int run_load;

    // every block input known from time zero
    rst                      = 1'b1;
    cfg_we                   = 1'b0;
    cfg_index                = '0;
    cfg_data                 = '0;
    sample_ch.valid          = 1'b0;
    sample_ch.target_load    = '0;
    sample_ch.measured_power = '0;
    result_ch.ready          = 1'b0;

    // register reset values: smoothing one, everything else zero
    reg_mode    = MODE_NONE;
    reg_percent = 0;
    reg_watts   = 0;
    reg_alpha   = 65536;
    reg_kp      = 0;
    reg_ki      = 0;
    reg_kd      = 0;
    pid_smooth   = 0;
    pid_err      = 0;
    pid_err_prev = 0;
    pid_integral = 0;
    pid_adj      = 0;
    pid_p        = 0;
    pid_i        = 0;
    pid_d        = 0;
    offsets_owed  = 0;
    sample_taken  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    fault_count   = 0;
    stall_cycles  = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // mode none straight out of reset, zero fields and field extremes
    queue_sample(0, 0, 1'b0);
    queue_sample(4095, 4095, 1'b0);
    queue_sample(1, 0, 1'b0);
    queue_sample(0, 4095, 1'b0);
    wait_idle();

    // manual at the top of scale and watts
    write_reg(CFG_OFFSET_MODE, MODE_MANUAL);
    write_reg(CFG_MANUAL_PCT, 1000);
    write_reg(CFG_MANUAL_W, 1000);
    queue_sample(4095, 4095, 1'b0);
    queue_sample(1, 4095, 1'b0);
    wait_idle();

    // manual with zero scale and the most negative offset; negative quotient truncates
    write_reg(CFG_MANUAL_PCT, 0);
    write_reg(CFG_MANUAL_W, -1000);
    queue_sample(4095, 7, 1'b0);
    queue_sample(3, 3, 1'b0);
    wait_idle();

    // field extremes beyond the documented range, plus a zero request in manual
    write_reg(CFG_MANUAL_PCT, 1023);
    write_reg(CFG_MANUAL_W, -1024);
    queue_sample(4095, 1, 1'b0);
    queue_sample(100, 0, 1'b0);
    wait_idle();

    // reserved mode code behaves as none
    write_reg(CFG_OFFSET_MODE, MODE_RSVD);
    queue_sample(4095, 4095, 1'b0);
    wait_idle();

    // auto with a smoothing weight above one and extreme gains
    write_reg(CFG_OFFSET_MODE, MODE_AUTO);
    write_reg(CFG_SMOOTHING, 131071);
    write_reg(CFG_GAIN_P, 32767);
    write_reg(CFG_GAIN_I, -32768);
    write_reg(CFG_GAIN_D, 32767);
    queue_sample(4095, 1, 1'b0);
    queue_sample(1, 4095, 1'b0);
    queue_sample(4095, 4095, 1'b0);
    queue_sample(0, 17, 1'b0);
    queue_sample(2048, 1000, 1'b0);
    wait_idle();

    // zero weight freezes the smoothed power
    write_reg(CFG_SMOOTHING, 0);
    queue_sample(4095, 4095, 1'b0);
    queue_sample(1, 1, 1'b0);
    wait_idle();

    // leaving auto keeps the stored error and terms in the result
    write_reg(CFG_OFFSET_MODE, MODE_NONE);
    queue_sample(4000, 10, 1'b0);
    wait_idle();
    write_reg(CFG_OFFSET_MODE, MODE_MANUAL);
    queue_sample(4000, 10, 1'b0);
    wait_idle();

    // the unused register index must be ignored
    write_reg(CFG_UNUSED, $urandom_range(131071));

    // ---- integral soak ----
    // Constant max error grows the integral every step with both gains at their
    // top; then both gains flip negative with the same integral.
    write_reg(CFG_OFFSET_MODE, MODE_AUTO);
    write_reg(CFG_SMOOTHING, 65536);
    write_reg(CFG_GAIN_P, 32767);
    write_reg(CFG_GAIN_I, 32767);
    write_reg(CFG_GAIN_D, 0);
    for (n = 0; n < SOAK_REQUESTS; n++)
      queue_sample(4095, 1, n == 0);
    wait_idle();
    write_reg(CFG_GAIN_P, -32768);
    write_reg(CFG_GAIN_I, -32768);
    for (n = 0; n < 5; n++)
      queue_sample(4095, 1, 1'b0);
    wait_idle();

    // ---- random phases ----
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      // idle pattern rotates: none, sender gaps, receiver stalls, both
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 54; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 54; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase

      // auto half the time, since that is where the state lives
      kind = $urandom_range(99);
      if (kind < 50)      write_reg(CFG_OFFSET_MODE, MODE_AUTO);
      else if (kind < 70) write_reg(CFG_OFFSET_MODE, MODE_MANUAL);
      else if (kind < 85) write_reg(CFG_OFFSET_MODE, MODE_NONE);
      else                write_reg(CFG_OFFSET_MODE, MODE_RSVD);
      write_reg(CFG_MANUAL_PCT, $urandom_range(1023));
      write_reg(CFG_MANUAL_W, $urandom_range(2047));
      case ($urandom_range(4))
        0: write_reg(CFG_SMOOTHING, 0);
        1: write_reg(CFG_SMOOTHING, 65536);
        2: write_reg(CFG_SMOOTHING, $urandom_range(131071));
        3: write_reg(CFG_SMOOTHING, $urandom_range(65535, 1));
        default: write_reg(CFG_SMOOTHING, $urandom_range(65536, 40000));
      endcase
      // raw 16-bit gains; 32767 and 32768 are the signed extremes
      write_reg(CFG_GAIN_P, ($urandom_range(3) == 0) ? 32767 : $urandom_range(65535));
      write_reg(CFG_GAIN_I, ($urandom_range(3) == 0) ? 32768 : $urandom_range(65535));
      write_reg(CFG_GAIN_D, $urandom_range(65535));

      run_load = $urandom_range(4095, 1);
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        kind = $urandom_range(99);
        if (kind < 6) begin
          // zero field: clears the controller
          ld = $urandom_range(1) ? 0 : $urandom_range(4095);
          pw = (ld == 0) ? $urandom_range(4095) : 0;
        end else if (kind < 25) begin
          ld = $urandom_range(4095, 1);
          pw = $urandom_range(4095, 1);
        end else begin
          // tracking run: steady load, power wandering around it
          if ($urandom_range(9) == 0) run_load = $urandom_range(4095, 1);
          ld = run_load;
          pw = run_load + int'($urandom_range(400)) - 200;
          if (pw < 1) pw = 1;
          if (pw > 4095) pw = 4095;
        end
        queue_sample(ld, pw, (ph == 2 && n == 0) || $urandom_range(39) == 0);
      end
    end

    // drain, then give a stray late result time to show up
    wait_idle();
    if (fault_count == 0 && expected_offsets.size() == 0) begin
      $display("trainer_load_offset_pid_top regression: pass");
    end else begin
      $display("trainer_load_offset_pid_top regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tlo_pkg.sv
rtl/core/tlo_if.sv
rtl/core/tlo_ctrl.sv
rtl/core/tlo_datapath.sv
rtl/core/trainer_load_offset_pid_top.sv
rtl/core/tlo_checker.sv
verif/tb_trainer_load_offset_pid_top.sv
